// ===== hdl/sbps_pkg.sv =====
// Shared types, constants and helpers for the spectrum bar parser and smoother.
`default_nettype none

package sbps_pkg;

	localparam int MAX_BANDS     = 64;
	localparam int FRACTION_BITS = 10;

	localparam int BAND_IDX_W = 6;   // band_index field width
	localparam int BAND_CNT_W = 7;   // holds 0..MAX_BANDS
	localparam int LEVEL_W    = 10;  // parsed level / full_scale width
	localparam int SMOOTH_W   = 20;  // smoothed value width
	localparam int WEIGHT_W   = 11;  // Q10 weight register width
	localparam int WEIGHT_FB  = 10;  // fraction bits of the weights
	localparam int DIGIT_W    = LEVEL_W + 4;  // v*10 + d before clamping

	localparam int HOLD_W = SMOOTH_W + WEIGHT_W;               // s * (1 - w)
	localparam int NEW_W  = LEVEL_W + WEIGHT_W;                // level * w
	localparam int ACC_W  = LEVEL_W + WEIGHT_W + FRACTION_BITS + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FB);
	localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(1 << (WEIGHT_FB - 1));

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [BAND_CNT_W-1:0] BARS_RESET    = 7'd48;
	localparam logic [LEVEL_W-1:0]    FULL_RESET    = 10'd100;
	localparam logic [WEIGHT_W-1:0]   ATTACK_RESET  = 11'd512;
	localparam logic [WEIGHT_W-1:0]   RELEASE_RESET = 11'd123;

	// stream characters
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BARS       = 2'd0,
		CFG_FULL_SCALE = 2'd1,
		CFG_ATTACK     = 2'd2,
		CFG_RELEASE    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] text_byte;
	} in_word_t;

	typedef struct packed {
		logic [BAND_IDX_W-1:0] band_index;
		logic [SMOOTH_W-1:0]   smoothed_level;
		logic                  last_band;
	} out_word_t;

	typedef struct packed {
		logic bad;
		logic point;
		logic digit;
	} field_flags_t;

	// controller -> datapath
	typedef struct packed {
		logic                  byte_en;
		logic [7:0]            text_byte;
		logic                  copy_rd_en;
		logic [BAND_IDX_W-1:0] copy_addr;
		logic                  rd_en;
		logic [BAND_IDX_W-1:0] rd_addr;
		logic                  mul_en;
		logic                  sum_en;
		logic [BAND_IDX_W-1:0] idx;
		logic                  last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic                  commit;
		logic [BAND_CNT_W-1:0] commit_len;
		logic [BAND_IDX_W-1:0] last_idx;
		logic                  out_free;
	} sts_t;

	function automatic logic [BAND_CNT_W-1:0] bands_active(input logic [BAND_CNT_W-1:0] bars);
		logic [BAND_CNT_W-1:0] n;
		n = bars;
		if (n == '0)
			n = BAND_CNT_W'(1);
		else if (n > BAND_CNT_W'(MAX_BANDS))
			n = BAND_CNT_W'(MAX_BANDS);
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sbps_datapath.sv =====
// Datapath: config registers, field parser, band memories, smoothing arithmetic, output register.
`default_nettype none

module sbps_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [sbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sbps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire sbps_pkg::cmd_t                cmd,
	output sbps_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output sbps_pkg::out_word_t                out_data
);

	// config
	logic [sbps_pkg::BAND_CNT_W-1:0] bars_q;
	logic [sbps_pkg::LEVEL_W-1:0]    full_scale_q;
	logic [sbps_pkg::WEIGHT_W-1:0]   attack_q;
	logic [sbps_pkg::WEIGHT_W-1:0]   release_q;
	logic [sbps_pkg::BAND_CNT_W-1:0] n_bands;

	// parser
	logic [sbps_pkg::LEVEL_W-1:0]    field_value_q;
	sbps_pkg::field_flags_t          field_flags_q;
	logic [sbps_pkg::BAND_CNT_W-1:0] pending_count_q;
	logic                            is_semi, is_nl, is_digit, is_point, closing, append;
	logic [sbps_pkg::LEVEL_W-1:0]    close_val;
	logic [sbps_pkg::BAND_CNT_W-1:0] count_after;
	logic [sbps_pkg::DIGIT_W-1:0]    digit_sum;
	logic [sbps_pkg::LEVEL_W-1:0]    digit_val;

	// memories
	logic [sbps_pkg::LEVEL_W-1:0]  pend_mem   [sbps_pkg::MAX_BANDS];
	logic [sbps_pkg::LEVEL_W-1:0]  band_mem   [sbps_pkg::MAX_BANDS];
	logic [sbps_pkg::SMOOTH_W-1:0] smooth_mem [sbps_pkg::MAX_BANDS];
	logic [sbps_pkg::MAX_BANDS-1:0] band_vld_q;
	logic [sbps_pkg::MAX_BANDS-1:0] smooth_vld_q;

	// copy pipe
	logic [sbps_pkg::LEVEL_W-1:0]    pend_rd_s1;
	logic [sbps_pkg::BAND_IDX_W-1:0] copy_addr_s1;
	logic                            copy_wr_s1;

	// smoothing pipe
	logic [sbps_pkg::LEVEL_W-1:0]  band_rd_s1;
	logic [sbps_pkg::SMOOTH_W-1:0] smooth_rd_s1;
	logic                          band_vld_s1, smooth_vld_s1;
	logic [sbps_pkg::LEVEL_W-1:0]  lvl;
	logic [sbps_pkg::SMOOTH_W-1:0] s_cur, t_cur;
	logic [sbps_pkg::WEIGHT_W-1:0] w_raw, w_lim, w_hold;
	logic [sbps_pkg::HOLD_W-1:0]   p_hold_s2;
	logic [sbps_pkg::NEW_W-1:0]    p_new_s2;
	logic [sbps_pkg::ACC_W-1:0]    acc;
	logic [sbps_pkg::SMOOTH_W-1:0] s_next;

	logic                out_valid_q;
	sbps_pkg::out_word_t out_data_q;

	// ---------------- config ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bars_q       <= sbps_pkg::BARS_RESET;
			full_scale_q <= sbps_pkg::FULL_RESET;
			attack_q     <= sbps_pkg::ATTACK_RESET;
			release_q    <= sbps_pkg::RELEASE_RESET;
		end else if (cfg_valid) begin
			unique case (sbps_pkg::cfg_idx_t'(cfg_index))
				sbps_pkg::CFG_BARS:       bars_q       <= cfg_data[sbps_pkg::BAND_CNT_W-1:0];
				sbps_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data[sbps_pkg::LEVEL_W-1:0];
				sbps_pkg::CFG_ATTACK:     attack_q     <= cfg_data[sbps_pkg::WEIGHT_W-1:0];
				sbps_pkg::CFG_RELEASE:    release_q    <= cfg_data[sbps_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_bands = sbps_pkg::bands_active(bars_q);

	// ---------------- parser ----------------
	always_comb begin
		is_semi  = cmd.text_byte == sbps_pkg::CH_SEMI;
		is_nl    = cmd.text_byte == sbps_pkg::CH_NEWLINE;
		is_point = cmd.text_byte == sbps_pkg::CH_POINT;
		is_digit = (cmd.text_byte >= sbps_pkg::CH_ZERO) && (cmd.text_byte <= sbps_pkg::CH_NINE);
		closing  = cmd.byte_en && (is_semi || is_nl);
		// a field counts once any non-separator byte has arrived in it
		append   = closing && (field_flags_q != '0) && (pending_count_q < n_bands);
		close_val = field_flags_q.bad ? '0 : field_value_q;
		count_after = pending_count_q + sbps_pkg::BAND_CNT_W'(append);
		digit_sum = sbps_pkg::DIGIT_W'(field_value_q) * sbps_pkg::DIGIT_W'(10)
			+ sbps_pkg::DIGIT_W'(cmd.text_byte - sbps_pkg::CH_ZERO);
		digit_val = (digit_sum > sbps_pkg::DIGIT_W'(full_scale_q)) ? full_scale_q
			: digit_sum[sbps_pkg::LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_value_q   <= '0;
			field_flags_q   <= '0;
			pending_count_q <= '0;
		end else if (cmd.byte_en) begin
			if (closing) begin
				field_value_q   <= '0;
				field_flags_q   <= '0;
				pending_count_q <= is_nl ? '0 : count_after;
			end else if (is_digit) begin
				field_flags_q.digit <= 1'b1;
				if (!field_flags_q.point && !field_flags_q.bad)
					field_value_q <= digit_val;
			end else if (is_point) begin
				if (field_flags_q.point)
					field_flags_q.bad <= 1'b1;
				field_flags_q.point <= 1'b1;
			end else begin
				field_flags_q.bad <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (append)
			pend_mem[pending_count_q[sbps_pkg::BAND_IDX_W-1:0]] <= close_val;
	end

	// ---------------- line commit: pending -> band levels ----------------
	always_ff @(posedge clk) begin
		if (cmd.copy_rd_en) begin
			pend_rd_s1   <= pend_mem[cmd.copy_addr];
			copy_addr_s1 <= cmd.copy_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (copy_wr_s1)
			band_mem[copy_addr_s1] <= pend_rd_s1;
		if (cmd.rd_en)
			band_rd_s1 <= band_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en)
			smooth_mem[cmd.idx] <= s_next;
		if (cmd.rd_en)
			smooth_rd_s1 <= smooth_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_wr_s1    <= 1'b0;
			band_vld_q    <= '0;
			smooth_vld_q  <= '0;
			band_vld_s1   <= 1'b0;
			smooth_vld_s1 <= 1'b0;
		end else begin
			copy_wr_s1 <= cmd.copy_rd_en;
			if (copy_wr_s1)
				band_vld_q[copy_addr_s1] <= 1'b1;
			if (cmd.sum_en)
				smooth_vld_q[cmd.idx] <= 1'b1;
			if (cmd.rd_en) begin
				band_vld_s1   <= band_vld_q[cmd.rd_addr];
				smooth_vld_s1 <= smooth_vld_q[cmd.rd_addr];
			end
		end
	end

	// ---------------- smoothing ----------------
	always_comb begin
		lvl   = band_vld_s1 ? band_rd_s1 : '0;
		s_cur = smooth_vld_s1 ? smooth_rd_s1 : '0;
		t_cur = sbps_pkg::SMOOTH_W'({lvl, sbps_pkg::FRACTION_BITS'(0)});
		w_raw = (t_cur > s_cur) ? attack_q : release_q;
		w_lim = (w_raw > sbps_pkg::WEIGHT_ONE) ? sbps_pkg::WEIGHT_ONE : w_raw;
		w_hold = sbps_pkg::WEIGHT_ONE - w_lim;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			p_hold_s2 <= sbps_pkg::HOLD_W'(s_cur) * sbps_pkg::HOLD_W'(w_hold);
			p_new_s2  <= sbps_pkg::NEW_W'(lvl) * sbps_pkg::NEW_W'(w_lim);
		end
	end

	always_comb begin
		acc = sbps_pkg::ACC_W'(p_hold_s2)
			+ sbps_pkg::ACC_W'({p_new_s2, sbps_pkg::FRACTION_BITS'(0)})
			+ sbps_pkg::ROUND_HALF;
		s_next = acc[sbps_pkg::WEIGHT_FB +: sbps_pkg::SMOOTH_W];
	end

	// ---------------- output word ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.sum_en)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			out_data_q.band_index     <= cmd.idx;
			out_data_q.smoothed_level <= s_next;
			out_data_q.last_band      <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sts.commit     = cmd.byte_en && is_nl && (count_after != '0);
		sts.commit_len = count_after;
		sts.last_idx   = sbps_pkg::BAND_IDX_W'(n_bands - sbps_pkg::BAND_CNT_W'(1));
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== hdl/sbps_ctrl.sv =====
// Controller: sequences byte intake, line-commit copy and the per-band smoothing walk.
`default_nettype none

module sbps_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sbps_pkg::in_word_t in_data,
	input  wire sbps_pkg::sts_t     sts,
	output sbps_pkg::cmd_t          cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_RD,
		ST_MUL,
		ST_SUM
	} state_t;

	state_t                          state_q;
	logic [sbps_pkg::BAND_IDX_W-1:0] idx_q;
	logic [sbps_pkg::BAND_IDX_W-1:0] copy_last_q;
	logic                            in_fire;
	logic                            at_last;

	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign at_last  = idx_q == sts.last_idx;

	always_comb begin
		cmd.byte_en    = in_fire && (in_data.operation == sbps_pkg::OP_BYTE);
		cmd.text_byte  = in_data.text_byte;
		cmd.copy_rd_en = state_q == ST_COPY;
		cmd.copy_addr  = idx_q;
		// the next band's read is issued while the current one retires
		cmd.rd_en      = (state_q == ST_RD)
			|| ((state_q == ST_SUM) && sts.out_free && !at_last);
		cmd.rd_addr    = (state_q == ST_RD) ? idx_q : idx_q + sbps_pkg::BAND_IDX_W'(1);
		cmd.mul_en     = state_q == ST_MUL;
		cmd.sum_en     = (state_q == ST_SUM) && sts.out_free;
		cmd.idx        = idx_q;
		cmd.last       = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			copy_last_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						if (in_data.operation == sbps_pkg::OP_TICK) begin
							state_q <= ST_RD;
						end else if (sts.commit) begin
							copy_last_q <= sbps_pkg::BAND_IDX_W'(sts.commit_len
								- sbps_pkg::BAND_CNT_W'(1));
							state_q <= ST_COPY;
						end
					end
				end
				ST_COPY: begin
					if (idx_q == copy_last_q)
						state_q <= ST_IDLE;
					else
						idx_q <= idx_q + sbps_pkg::BAND_IDX_W'(1);
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (sts.out_free) begin
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + sbps_pkg::BAND_IDX_W'(1);
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/spectrum_bar_parse_and_smooth_top.sv =====
// Top level of the spectrum bar parser and attack/release smoother.
//
// in channel: one word per item; operation selects a text byte or a frame tick.
// Text bytes are taken one per cycle. A newline that closes a line holding k
// fields copies them into the band levels, one band per cycle, and input stalls
// while the copy runs (the pending memory has one read port).
// A tick walks the bands in use through the same two multipliers: the walk
// steps through read, multiply and sum states, then multiply and sum for each
// further band, with that band's read issued during the previous sum. Input is
// not taken during the walk.
// out channel: band_index, smoothed_level (Q10), last_band on the final band.
// A registered output word parts the two sides; when the receiver stalls the
// walk holds at the current band and resumes when the word is taken. Bytes
// are accepted while the last word of a tick still waits.
// cfg channel: always ready; writes take effect at once and are meant for idle.
// Reset: registers return to 48 bands, full scale 100, weights 512 and 123;
// band levels and smoothed values read as zero, the field parser is empty.
`default_nettype none

module spectrum_bar_parse_and_smooth_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire sbps_pkg::in_word_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output sbps_pkg::out_word_t                  out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sbps_pkg::CFG_DATA_W-1:0] cfg_data
);

	sbps_pkg::cmd_t cmd;
	sbps_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== hdl/sbps_checker.sv =====
// Port-level checks for the spectrum bar parser and smoother, bound to the top level.
`default_nettype none

module sbps_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire sbps_pkg::in_word_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire sbps_pkg::out_word_t out_data
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// a tick starts a band walk, so no input right after it
	a_tick_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.operation == sbps_pkg::OP_TICK) |=> !in_ready)
		else $error("input taken right after a tick");

	// mid-walk words only appear while input is blocked
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_band |-> !in_ready)
		else $error("input ready while a band walk is unfinished");

	// a weighted average never leaves the level range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.smoothed_level <= 20'd1047552)
		else $error("smoothed level above full range");

endmodule

bind spectrum_bar_parse_and_smooth_top sbps_checker u_sbps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== dv/tb_spectrum_bar_parse_and_smooth_top.sv =====
// Testbench for the bar level parser and smoother: random and directed text, scoreboard checks.
`timescale 1ns / 1ps

module tb_spectrum_bar_parse_and_smooth_top;
	import sbps_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int DRAIN_CYCLES    = 100;   // long enough for a newline copy
	localparam int HOLD_CYCLES     = 400;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int NUM_PHASES      = 8;
	localparam int MAX_REPORTS     = 40;
	localparam longint TIMEOUT_NS  = 5_000_000;
	localparam longint unsigned Q_ONE = 1 << WEIGHT_FB;

	// parser and envelope state, mirrored per accepted word
	class bar_scoreboard;
		int unsigned bars_cfg, full_cfg, attack_cfg, release_cfg;
		logic [LEVEL_W-1:0]  pending_lvl [MAX_BANDS];
		int unsigned         pending_cnt;
		int unsigned         field_val;
		field_flags_t        flags;
		logic [LEVEL_W-1:0]  band_lvl [MAX_BANDS];
		logic [SMOOTH_W-1:0] smooth_lvl [MAX_BANDS];
		out_word_t           expected_bands [$];
		int unsigned         fail_count;

		function new();
			bars_cfg    = BARS_RESET;
			full_cfg    = FULL_RESET;
			attack_cfg  = ATTACK_RESET;
			release_cfg = RELEASE_RESET;
			pending_cnt = 0;
			field_val   = 0;
			flags       = '0;
			fail_count  = 0;
			for (int i = 0; i < MAX_BANDS; i++) begin
				pending_lvl[i] = '0;
				band_lvl[i]    = '0;
				smooth_lvl[i]  = '0;
			end
		endfunction

		function int unsigned active_bands();
			if (bars_cfg == 0)
				return 1;
			if (bars_cfg > MAX_BANDS)
				return MAX_BANDS;
			return bars_cfg;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_BARS:       bars_cfg    = value[BAND_CNT_W-1:0];
				CFG_FULL_SCALE: full_cfg    = value[LEVEL_W-1:0];
				CFG_ATTACK:     attack_cfg  = value[WEIGHT_W-1:0];
				CFG_RELEASE:    release_cfg = value[WEIGHT_W-1:0];
				default: ;
			endcase
		endfunction

		function void close_field();
			if (flags != '0 && pending_cnt < active_bands()) begin
				pending_lvl[pending_cnt] = flags.bad ? '0 : LEVEL_W'(field_val);
				pending_cnt++;
			end
			field_val = 0;
			flags     = '0;
		endfunction

		function void take_text(logic [7:0] c);
			int unsigned v;
			if (c == CH_SEMI) begin
				close_field();
			end else if (c == CH_NEWLINE) begin
				close_field();
				for (int i = 0; i < pending_cnt && i < MAX_BANDS; i++)
					band_lvl[i] = pending_lvl[i];
				pending_cnt = 0;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				flags.digit = 1'b1;
				if (!flags.point && !flags.bad) begin
					v = field_val * 10 + (c - CH_ZERO);
					field_val = (v > full_cfg) ? full_cfg : v;
				end
			end else if (c == CH_POINT) begin
				if (flags.point)
					flags.bad = 1'b1;
				flags.point = 1'b1;
			end else begin
				flags.bad = 1'b1;
			end
		endfunction

		function void smooth_all();
			longint unsigned t, s, w;
			int unsigned n;
			out_word_t o;
			n = active_bands();
			for (int i = 0; i < n; i++) begin
				t = 64'(band_lvl[i]) << FRACTION_BITS;
				s = 64'(smooth_lvl[i]);
				w = (t > s) ? attack_cfg : release_cfg;
				if (w > Q_ONE)
					w = Q_ONE;
				s = (s * (Q_ONE - w) + t * w + (Q_ONE >> 1)) >> WEIGHT_FB;
				smooth_lvl[i]    = SMOOTH_W'(s);
				o.band_index     = BAND_IDX_W'(i);
				o.smoothed_level = SMOOTH_W'(s);
				o.last_band      = (i + 1 == n);
				expected_bands   = {expected_bands, o};
			end
		endfunction

		function void note_word(in_word_t w);
			if (w.operation == OP_TICK)
				smooth_all();
			else
				take_text(w.text_byte);
		endfunction

		function void check_word(out_word_t got);
			out_word_t exp_w;
			if (expected_bands.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t unexpected word: expected none, actual band %0d level %0d last %0b",
						$time, got.band_index, got.smoothed_level, got.last_band);
				fail_count++;
				return;
			end
			exp_w = expected_bands.pop_front();
			if (got.band_index != exp_w.band_index || got.smoothed_level != exp_w.smoothed_level
					|| got.last_band != exp_w.last_band) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t mismatch: expected band %0d level %0d last %0b, actual band %0d level %0d last %0b",
						$time, exp_w.band_index, exp_w.smoothed_level, exp_w.last_band,
						got.band_index, got.smoothed_level, got.last_band);
				fail_count++;
			end
		endfunction

		function int outstanding();
			return expected_bands.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_BARS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bar_scoreboard sb = new();
	in_word_t      stim_q [$];
	int unsigned   tx_idle_pct = 0;
	int unsigned   rx_idle_pct = 0;
	int            hold_req_cnt = 0;
	int            hold_ack_cnt = 0;
	int            hold_left = 0;
	string         bad_chars = "- \015.+x";

	spectrum_bar_parse_and_smooth_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// receiver: check each taken word, then pick next ready
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_word(out_data);
		if (hold_req_cnt != hold_ack_cnt) begin
			hold_ack_cnt <= hold_req_cnt;
			hold_left    <= HOLD_CYCLES;
			out_ready    <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_spectrum_bar_parse_and_smooth_top failed");
		$finish;
	end

	function automatic void queue_byte(logic [7:0] b);
		in_word_t w;
		w.operation = OP_BYTE;
		w.text_byte = b;
		stim_q = {stim_q, w};
	endfunction

	function automatic void queue_tick();
		in_word_t w;
		w.operation = OP_TICK;
		w.text_byte = 8'($urandom_range(0, 255));  // ignored by the block
		stim_q = {stim_q, w};
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endfunction

	task automatic drive_stream();
		in_word_t w;
		while (stim_q.size() != 0) begin
			w = stim_q.pop_front();
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_data  <= w;
			do @(posedge clk); while (!in_ready);
			sb.note_word(w);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(int unsigned bars, int unsigned full, int unsigned atk,
			int unsigned rel);
		int unsigned values [4];
		cfg_idx_t    idx;
		values[CFG_BARS]       = bars;
		values[CFG_FULL_SCALE] = full;
		values[CFG_ATTACK]     = atk;
		values[CFG_RELEASE]    = rel;
		wait_idle();
		idx = CFG_BARS;
		repeat (4) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= CFG_DATA_W'(values[idx]);
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx, CFG_DATA_W'(values[idx]));
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned ph_bars [NUM_PHASES];
		int unsigned ph_full [NUM_PHASES];
		int unsigned ph_attack [NUM_PHASES];
		int unsigned ph_release [NUM_PHASES];
		int r, nfields, kind, ndig;

		ph_bars    = '{64, 1, 127, 5, 48, 0, 64, 0};
		ph_full    = '{1000, 1, 0, 37, 100, 0, 1023, 0};
		ph_attack  = '{1024, 0, 2047, 300, 512, 0, 1, 0};
		ph_release = '{0, 1024, 2047, 900, 123, 0, 1023, 0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: saturation, empty field, fraction, bad sign, double point, empty line
		tx_idle_pct = 12;
		rx_idle_pct <= 45;
		queue_text("999;;5.7;-3;1.2.3");
		queue_byte(CH_NEWLINE);
		queue_tick();
		queue_byte(CH_NEWLINE);
		queue_tick();
		drive_stream();

		// zero bands in use acts as one; extra fields dropped
		set_config(0, 100, 512, 123);
		queue_text("4;5");
		queue_byte(CH_NEWLINE);
		queue_tick();
		drive_stream();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 3) begin
				tx_idle_pct = 45;
				rx_idle_pct <= 12;
			end else if (ph == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			if (ph == 5 || ph == 7)
				set_config($urandom_range(0, 127), $urandom_range(0, 1023),
					$urandom_range(0, 2047), $urandom_range(0, 2047));
			else
				set_config(ph_bars[ph], ph_full[ph], ph_attack[ph], ph_release[ph]);

			if (ph == 4) begin
				// long receiver hold: output backs up and the input stalls
				queue_tick();
				hold_req_cnt <= hold_req_cnt + 1;
			end

			while (stim_q.size() < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					nfields = $urandom_range(0, 9);
					for (int f = 0; f < nfields; f++) begin
						kind = $urandom_range(0, 99);
						if (kind >= 12) begin
							ndig = $urandom_range(1, 4);
							repeat (ndig) queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
							if (kind < 30) begin
								queue_byte(CH_POINT);
								repeat ($urandom_range(0, 2))
									queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
							end
							if (kind >= 88) begin
								if (kind >= 96)
									queue_byte(8'($urandom_range(0, 255)));
								else
									queue_byte(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
							end
						end
						if (f + 1 < nfields || $urandom_range(0, 3) == 0)
							queue_byte(CH_SEMI);
					end
					queue_byte(CH_NEWLINE);
					if ($urandom_range(0, 1) == 1)
						queue_tick();
				end else if (r < 85) begin
					queue_tick();
				end else begin
					repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
				end
			end
			drive_stream();
		end

		wait_idle();
		if (sb.fail_count == 0 && sb.outstanding() == 0)
			$display("tb_spectrum_bar_parse_and_smooth_top passed");
		else
			$display("tb_spectrum_bar_parse_and_smooth_top failed");
		$finish;
	end

endmodule
